[rtl/bsp_pkg.sv]
// Shared constants, types and codes for the B-spline point evaluator.
package bsp_pkg;

   // Sizes of the design.
   localparam int MAX_POINTS  = 64;
   localparam int MAX_DEGREE  = 7;
   localparam int COORD_BITS  = 11;
   localparam int T_FRAC_BITS = 16;
   localparam int PT_FRAC     = 16;

   localparam int IDX_BITS   = $clog2(MAX_POINTS);
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DEG_BITS   = $clog2(MAX_DEGREE + 1);
   localparam int T_BITS     = T_FRAC_BITS + 1;
   localparam int PT_BITS    = COORD_BITS + PT_FRAC + 1;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = CNT_BITS;

   // Parameter 1.0 in the t format and in the blend weight format.
   localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

   // Operation codes of an input item.
   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } opcode_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEGREE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COUNT  = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [DEG_BITS-1:0] DEGREE_RESET = 3'd4;
   localparam logic [CNT_BITS-1:0] COUNT_RESET  = 7'd0;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [PT_BITS-1:0]    point_type;

endpackage

[rtl/bspline_de_boor_point_eval.sv]
// Top level of the B-spline point evaluator: sequencer, shared divider and multiplier.
//
//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_ready   | opcode, point_index, point_x, point_y, param_t
//  rsp     | out       | rsp_valid / rsp_ready   | curve_x, curve_y, result_valid
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// A write item stores its point and the sequencer stays idle. An evaluate item with too few points
// gives an invalid, zeroed result without blending. Otherwise the blend steps use the 16-step shared
// divider, run up to three times per blend step (two knots, one weight).
// Reset clears only control state; point and blend memories hold no reset value.
// A result waits in the output register while rsp_ready is low; no new item is taken then.
module bspline_de_boor_point_eval (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_opcode,
   input  logic [bsp_pkg::IDX_BITS-1:0]         req_point_index,
   input  logic [bsp_pkg::COORD_BITS-1:0]       req_point_x,
   input  logic [bsp_pkg::COORD_BITS-1:0]       req_point_y,
   input  logic [bsp_pkg::T_BITS-1:0]           req_param_t,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bsp_pkg::COORD_BITS-1:0]       rsp_curve_x,
   output logic [bsp_pkg::COORD_BITS-1:0]       rsp_curve_y,
   output logic                                 rsp_result_valid,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bsp_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [bsp_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import bsp_pkg::*;

   localparam int WK_BITS  = 2 * PT_BITS;
   localparam int MUL_BITS = PT_BITS + T_BITS;
   localparam int DSTEP_BITS = $clog2(PT_FRAC + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPAN, ST_LD_RD, ST_LD_WR, ST_RD_HI, ST_RD_LO,
      ST_KA, ST_KB, ST_AL, ST_DIV, ST_MUL, ST_FIN, ST_FIN_WAIT, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DT_KA, DT_KB, DT_AL
   } div_tgt_type;

   // Registers.
   state_type                 state_ff, state_in;
   div_tgt_type               dsel_ff, dsel_in;
   logic [DEG_BITS-1:0]       degree_ff, degree_in;
   logic [CNT_BITS-1:0]       count_ff, count_in;
   logic [DEG_BITS-1:0]       deg_ff, deg_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [T_BITS-1:0]         t_ff, t_in;
   logic [IDX_BITS-1:0]       s_ff, s_in;
   logic [DEG_BITS-1:0]       li_ff, li_in;
   logic [DEG_BITS-1:0]       r_ff, r_in;
   logic [DEG_BITS-1:0]       i_ff, i_in;
   logic [WK_BITS-1:0]        cur_ff, cur_in;
   logic [WK_BITS-1:0]        prev_ff, prev_in;
   logic [T_BITS-1:0]         ka_ff, ka_in;
   logic [T_BITS-1:0]         kb_ff, kb_in;
   logic [T_BITS-1:0]         alpha_ff, alpha_in;
   logic [T_BITS-1:0]         rem_ff, rem_in;
   logic [T_BITS-1:0]         den_ff, den_in;
   logic [PT_FRAC-1:0]        quo_ff, quo_in;
   logic [DSTEP_BITS-1:0]     dstep_ff, dstep_in;
   logic [MUL_BITS-1:0]       acc_ff, acc_in;
   logic [PT_BITS-1:0]        newx_ff, newx_in;
   logic [1:0]                mcnt_ff, mcnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]     out_x_ff, out_x_in;
   logic [COORD_BITS-1:0]     out_y_ff, out_y_in;
   logic                      out_ok_ff, out_ok_in;

   // Memories and their ports.
   logic [2*COORD_BITS-1:0]   st_mem [MAX_POINTS];
   logic [2*COORD_BITS-1:0]   st_rd_ff;
   logic                      st_we;
   logic [IDX_BITS-1:0]       st_raddr;
   logic [WK_BITS-1:0]        wk_mem [MAX_DEGREE+1];
   logic [WK_BITS-1:0]        wk_rd_ff;
   logic                      wk_we;
   logic [DEG_BITS-1:0]       wk_waddr, wk_raddr;
   logic [WK_BITS-1:0]        wk_wdata;

   // Shared arithmetic.
   logic [PT_BITS-1:0]        mul_a;
   logic [T_BITS-1:0]         mul_b;
   logic [MUL_BITS-1:0]       mul_p, mul_sum;
   logic [T_BITS:0]           rem2;
   logic                      rem_ge;
   logic [T_BITS-1:0]         beta;
   logic [CNT_BITS:0]         sum_a, j_a, j_b;
   logic [T_BITS-1:0]         num, dif;
   logic                      req_fire, rsp_fire, csr_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_fire  = csr_valid && csr_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_curve_x      = out_x_ff;
   assign rsp_curve_y      = out_y_ff;
   assign rsp_result_valid = out_ok_ff;

   assign mul_p   = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);
   assign mul_sum = acc_ff + mul_p;
   assign beta    = T_ONE - alpha_ff;

   // One restoring division step.
   assign rem2   = {rem_ff, 1'b0};
   assign rem_ge = rem2 >= {1'b0, den_ff};

   // Knot offsets for the two ends of the current blend interval.
   always_comb begin
      sum_a = (CNT_BITS+1)'(i_ff) + (CNT_BITS+1)'(s_ff);
      j_a   = (sum_a > (CNT_BITS+1)'(deg_ff)) ? sum_a - (CNT_BITS+1)'(deg_ff) : '0;
      if (j_a > (CNT_BITS+1)'(cnt_ff)) begin
         j_a = (CNT_BITS+1)'(cnt_ff);
      end
      j_b = sum_a + (CNT_BITS+1)'(1) - (CNT_BITS+1)'(r_ff);
      if (j_b > (CNT_BITS+1)'(cnt_ff)) begin
         j_b = (CNT_BITS+1)'(cnt_ff);
      end
      num = (t_ff > ka_ff) ? t_ff - ka_ff : '0;
      dif = kb_ff - ka_ff;
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      dsel_in      = dsel_ff;
      degree_in    = degree_ff;
      count_in     = count_ff;
      deg_in       = deg_ff;
      cnt_in       = cnt_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      li_in        = li_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      alpha_in     = alpha_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      dstep_in     = dstep_ff;
      acc_in       = acc_ff;
      newx_in      = newx_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_ok_in    = out_ok_ff;
      st_we        = 1'b0;
      st_raddr     = IDX_BITS'(s_ff + IDX_BITS'(li_ff));
      wk_we        = 1'b0;
      wk_waddr     = i_ff;
      wk_wdata     = '0;
      wk_raddr     = i_ff;
      mul_a        = PT_BITS'(cnt_ff);
      mul_b        = t_ff;

      // Configuration writes; the degree needs no saturation at three bits.
      if (csr_fire) begin
         if (csr_index == CSR_DEGREE) begin
            degree_in = csr_data[DEG_BITS-1:0];
         end else if (csr_index == CSR_COUNT) begin
            count_in = (csr_data > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : csr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_WRITE) begin
                  st_we = 1'b1;
               end else if (count_ff <= CNT_BITS'(degree_ff)) begin
                  // Too few points: an invalid, zeroed result.
                  out_x_in     = '0;
                  out_y_in     = '0;
                  out_ok_in    = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  deg_in   = degree_ff;
                  cnt_in   = count_ff - CNT_BITS'(degree_ff);
                  t_in     = (req_param_t > T_ONE) ? T_ONE : req_param_t;
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            // Span index from t times the interval count, clamped to the last one.
            if (mul_p[T_FRAC_BITS +: CNT_BITS] > cnt_ff - CNT_BITS'(1)) begin
               s_in = IDX_BITS'(cnt_ff - CNT_BITS'(1));
            end else begin
               s_in = mul_p[T_FRAC_BITS +: IDX_BITS];
            end
            li_in    = '0;
            state_in = ST_LD_RD;
         end
         ST_LD_RD: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            // Copy one control point into the blend memory as a fixed-point value.
            wk_we    = 1'b1;
            wk_waddr = li_ff;
            wk_wdata = {1'b0, st_rd_ff[2*COORD_BITS-1:COORD_BITS], PT_FRAC'(0),
                        1'b0, st_rd_ff[COORD_BITS-1:0], PT_FRAC'(0)};
            if (li_ff == deg_ff) begin
               r_in     = DEG_BITS'(1);
               i_in     = deg_ff;
               state_in = (deg_ff == '0) ? ST_FIN : ST_RD_HI;
            end else begin
               li_in    = li_ff + DEG_BITS'(1);
               state_in = ST_LD_RD;
            end
         end
         ST_RD_HI: begin
            wk_raddr = i_ff;
            state_in = ST_RD_LO;
         end
         ST_RD_LO: begin
            cur_in   = wk_rd_ff;
            wk_raddr = i_ff - DEG_BITS'(1);
            state_in = ST_KA;
         end
         ST_KA: begin
            prev_in = wk_rd_ff;
            if (j_a >= (CNT_BITS+1)'(cnt_ff)) begin
               ka_in    = T_ONE;
               state_in = ST_KB;
            end else begin
               rem_in   = T_BITS'(j_a);
               den_in   = T_BITS'(cnt_ff);
               dstep_in = '0;
               dsel_in  = DT_KA;
               state_in = ST_DIV;
            end
         end
         ST_KB: begin
            if (j_b >= (CNT_BITS+1)'(cnt_ff)) begin
               kb_in    = T_ONE;
               state_in = ST_AL;
            end else begin
               rem_in   = T_BITS'(j_b);
               den_in   = T_BITS'(cnt_ff);
               dstep_in = '0;
               dsel_in  = DT_KB;
               state_in = ST_DIV;
            end
         end
         ST_AL: begin
            // Weight of the upper point; an empty or overrun interval gives 1.0.
            if (kb_ff <= ka_ff || num >= dif) begin
               alpha_in = T_ONE;
               mcnt_in  = '0;
               state_in = ST_MUL;
            end else begin
               rem_in   = num;
               den_in   = dif;
               dstep_in = '0;
               dsel_in  = DT_AL;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Numerator below divisor: sixteen quotient bits, one per cycle.
            rem_in   = rem_ge ? T_BITS'(rem2 - {1'b0, den_ff}) : rem2[T_BITS-1:0];
            quo_in   = {quo_ff[PT_FRAC-2:0], rem_ge};
            dstep_in = dstep_ff + DSTEP_BITS'(1);
            if (dstep_ff == DSTEP_BITS'(PT_FRAC - 1)) begin
               case (dsel_ff)
                  DT_KA: begin
                     ka_in    = {1'b0, quo_ff[PT_FRAC-2:0], rem_ge};
                     state_in = ST_KB;
                  end
                  DT_KB: begin
                     kb_in    = {1'b0, quo_ff[PT_FRAC-2:0], rem_ge};
                     state_in = ST_AL;
                  end
                  default: begin
                     alpha_in = {1'b0, quo_ff[PT_FRAC-2:0], rem_ge};
                     mcnt_in  = '0;
                     state_in = ST_MUL;
                  end
               endcase
            end
         end
         ST_MUL: begin
            // Four products: upper x, lower x, upper y, lower y.
            case (mcnt_ff)
               2'd0: begin
                  mul_a = cur_ff[WK_BITS-1:PT_BITS];
                  mul_b = alpha_ff;
               end
               2'd1: begin
                  mul_a = prev_ff[WK_BITS-1:PT_BITS];
                  mul_b = beta;
               end
               2'd2: begin
                  mul_a = cur_ff[PT_BITS-1:0];
                  mul_b = alpha_ff;
               end
               default: begin
                  mul_a = prev_ff[PT_BITS-1:0];
                  mul_b = beta;
               end
            endcase
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff[0] == 1'b0) begin
               acc_in = mul_p;
            end else if (mcnt_ff == 2'd1) begin
               newx_in = mul_sum[PT_FRAC +: PT_BITS];
            end else begin
               wk_we    = 1'b1;
               wk_waddr = i_ff;
               wk_wdata = {newx_ff, mul_sum[PT_FRAC +: PT_BITS]};
               if (i_ff > r_ff) begin
                  i_in     = i_ff - DEG_BITS'(1);
                  state_in = ST_RD_HI;
               end else if (r_ff < deg_ff) begin
                  r_in     = r_ff + DEG_BITS'(1);
                  i_in     = deg_ff;
                  state_in = ST_RD_HI;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            wk_raddr = deg_ff;
            state_in = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            out_x_in     = wk_rd_ff[PT_BITS+PT_FRAC +: COORD_BITS];
            out_y_in     = wk_rd_ff[PT_FRAC +: COORD_BITS];
            out_ok_in    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         degree_ff    <= DEGREE_RESET;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dsel_ff   <= dsel_in;
      deg_ff    <= deg_in;
      cnt_ff    <= cnt_in;
      t_ff      <= t_in;
      s_ff      <= s_in;
      li_ff     <= li_in;
      r_ff      <= r_in;
      i_ff      <= i_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      ka_ff     <= ka_in;
      kb_ff     <= kb_in;
      alpha_ff  <= alpha_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      dstep_ff  <= dstep_in;
      acc_ff    <= acc_in;
      newx_ff   <= newx_in;
      mcnt_ff   <= mcnt_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_ok_ff <= out_ok_in;
   end

   // Control point memory.
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[req_point_index] <= {req_point_x, req_point_y};
      end
      st_rd_ff <= st_mem[st_raddr];
   end

   // Blend working memory.
   always_ff @(posedge clock) begin
      if (wk_we) begin
         wk_mem[wk_waddr] <= wk_wdata;
      end
      wk_rd_ff <= wk_mem[wk_raddr];
   end

   // A waiting result blocks new items.
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> !req_ready)
      else $error("input taken while a result waits");

   // An invalid result carries a zero point.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_ok_ff) |-> (out_x_ff == '0 && out_y_ff == '0))
      else $error("invalid result with nonzero point");

   // The blend weight never exceeds 1.0.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (alpha_ff <= T_ONE))
      else $error("blend weight above one");

   // An evaluate item always leaves the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_opcode == OP_EVAL) |=> !req_ready)
      else $error("evaluate item produced no work");

   // The divider never runs past its last quotient bit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dstep_ff < DSTEP_BITS'(PT_FRAC)))
      else $error("divider overran");

endmodule
